// ===== rtl/integer_to_ascii_radix_macros.svh =====
// Assertion macros shared by the integer to text converter.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ITOA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ITOA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ITOA_ASSERT_IMP(label, ante, cons, msg)
`define ITOA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/itoa_pkg.sv =====
// Shared constants, types and the digit to ASCII mapping of the converter.
// Depends on nothing.
package itoa_pkg;

  localparam int WORD_W          = 32;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 8;
  localparam int LEN_W           = 6;
  localparam int DIGIT_W         = 6;
  localparam int MAX_DIGITS      = 32;
  localparam int STEPS_PER_CYCLE = 8;
  localparam int DIV_CYCLES      = WORD_W / STEPS_PER_CYCLE;
  localparam int STEP_CNT_W      = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);
  localparam logic [DIGIT_W-1:0] DEC_DIGIT_MAX = DIGIT_W'(9);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_A     = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_last;
    logic emit_sign;
    logic emit_digit;
    logic emit_term;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic quot_zero;
    logic last_digit;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DEC_DIGIT_MAX) begin
      c = CHAR_W'(d - (DEC_DIGIT_MAX + DIGIT_W'(1))) + ASCII_A;
    end else begin
      c = CHAR_W'(d) + ASCII_ZERO;
    end
    return c;
  endfunction

endpackage

// ===== rtl/itoa_dp.sv =====
// Datapath of the converter: radix division unit, digit stack, output register.
// Depends on itoa_pkg.
module itoa_dp
  import itoa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [WORD_W-1:0]  in_value,
  input  logic        [RADIX_W-1:0] in_radix,
  input  cmd_t                      cmd,
  output status_t                   status,
  output logic                      out_strobe,
  output logic        [CHAR_W-1:0]  out_character,
  output logic                      out_last,
  output logic        [LEN_W-1:0]   out_total_length
);

  logic [WORD_W-1:0]  mag_r;
  logic [RADIX_W-1:0] rem_r;
  logic [RADIX_W-1:0] radix_r;
  logic               neg_r;
  logic [LEN_W-1:0]   nd_r;
  logic [LEN_W-1:0]   cnt_r;
  logic [DIGIT_W-1:0] stack_r [MAX_DIGITS];

  logic               strobe_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;
  logic [LEN_W-1:0]   len_r;

  logic [RADIX_W-1:0] radix_sat;
  logic               neg_in;
  logic [WORD_W-1:0]  mag_in;
  logic [WORD_W-1:0]  div_quot;
  logic [RADIX_W-1:0] div_rem;

  // Input conditioning: clamp the radix, take the magnitude only in base ten.
  always_comb begin
    if (!(in_radix inside {[RADIX_MIN:RADIX_MAX]})) begin
      radix_sat = (in_radix < RADIX_MIN) ? RADIX_MIN : RADIX_MAX;
    end else begin
      radix_sat = in_radix;
    end
    neg_in = in_value[WORD_W-1] && (radix_sat == RADIX_DEC);
    mag_in = neg_in ? (WORD_W'(0) - $unsigned(in_value)) : $unsigned(in_value);
  end

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [RADIX_W:0]   sh;
    logic [RADIX_W-1:0] r;
    logic [WORD_W-1:0]  q;
    r = rem_r;
    q = mag_r;
    for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
      sh = {r, q[WORD_W-1]};
      q  = {q[WORD_W-2:0], 1'b0};
      if (sh >= {1'b0, radix_r}) begin
        sh   = sh - {1'b0, radix_r};
        q[0] = 1'b1;
      end
      r = sh[RADIX_W-1:0];
    end
    div_quot = q;
    div_rem  = r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r   <= mag_in;
      radix_r <= radix_sat;
      neg_r   <= neg_in;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      mag_r <= div_quot;
      rem_r <= cmd.div_last ? '0 : div_rem;
    end
  end

  // Digit stack: the top sits at entry zero, pushes shift down, pops shift up.
  always_ff @(posedge clk) begin
    if (cmd.div_step && cmd.div_last) begin
      stack_r[0] <= div_rem;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (cmd.emit_digit) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.load) begin
      nd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.div_step && cmd.div_last) begin
        nd_r <= nd_r + LEN_W'(1);
      end else if (cmd.emit_digit) begin
        nd_r <= nd_r - LEN_W'(1);
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
        cnt_r <= cnt_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit_sign || cmd.emit_digit || cmd.emit_term;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_r <= ASCII_MINUS;
      last_r <= 1'b0;
      len_r  <= '0;
    end else if (cmd.emit_digit) begin
      char_r <= digit_char(stack_r[0]);
      last_r <= 1'b0;
      len_r  <= '0;
    end else if (cmd.emit_term) begin
      char_r <= ASCII_NUL;
      last_r <= 1'b1;
      len_r  <= cnt_r + LEN_W'(1);
    end
  end

  assign status.neg        = neg_r;
  assign status.quot_zero  = (div_quot == '0);
  assign status.last_digit = (nd_r == LEN_W'(1));

  assign out_strobe       = strobe_r;
  assign out_character    = char_r;
  assign out_last         = last_r;
  assign out_total_length = len_r;

endmodule

// ===== rtl/itoa_ctrl.sv =====
// Sequencer of the converter: division rounds, then sign, digits and terminator.
// Depends on itoa_pkg.
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3;
  localparam logic [2:0] ST_TERM  = 3'd4;

  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DIV_CYCLES - 1);

  logic [2:0]            state_r, state_nxt;
  logic [STEP_CNT_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_CNT_W'(1);
        if (step_r == STEP_LAST) begin
          cmd.div_last = 1'b1;
          if (status.quot_zero) begin
            state_nxt = status.neg ? ST_SIGN : ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd.emit_digit = 1'b1;
        if (status.last_digit) begin
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.emit_term = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== rtl/integer_to_ascii_radix.sv =====
// Top level of the integer to text converter in radix 2 to 36.
// Depends on itoa_pkg, itoa_ctrl, itoa_dp and integer_to_ascii_radix_macros.svh.
//
// A request is taken at a rising edge where start is high and busy is low.
// It turns a signed 32-bit value into ASCII characters, most significant
// digit first, with lower-case letters for digit values above nine. Only in
// radix ten does a negative value get a leading minus; in any other radix
// the value is read as its unsigned 32-bit pattern. A radix below two is
// treated as two and one above 36 as 36. Each character is shown for exactly
// one cycle with out_strobe high, and the receiver cannot stall it. The last
// character is always a NUL with out_last set, and its out_total_length is
// the number of characters of the request including that NUL.
// With D digits and S equal to one when a minus is shown, the block first
// divides once per digit (each digit is one 32-bit division by the radix,
// eight quotient bits per cycle through a shared restoring divider), then
// emits S + D + 1 characters at one per cycle. Busy stays high until the
// terminator has been issued, so the block takes no new request while
// the previous one is still in progress.

`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix
  import itoa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [WORD_W-1:0]  in_value,
  input  logic        [RADIX_W-1:0] in_radix,
  output logic                      out_strobe,
  output logic        [CHAR_W-1:0]  out_character,
  output logic                      out_last,
  output logic        [LEN_W-1:0]   out_total_length
);

  // The controller issues one command set per cycle and reads back the
  // datapath status: sign of the request, quotient reaching zero, and the
  // digit stack holding its final entry.
  cmd_t    cmd;
  status_t status;

  itoa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the running quotient and partial remainder, a stack
  // of computed digits (least significant pushed first, so popping yields
  // the most significant first), and the registered output character.
  itoa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .in_radix         (in_radix),
    .cmd              (cmd),
    .status           (status),
    .out_strobe       (out_strobe),
    .out_character    (out_character),
    .out_last         (out_last),
    .out_total_length (out_total_length)
  );

  // An accepted request keeps the block busy while it divides.
  `ITOA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")

  // The terminator is a NUL and carries a nonzero length.
  `ITOA_ASSERT_IMP(a_term_nul, out_strobe && out_last,
    (out_character == ASCII_NUL) && (out_total_length != '0), "terminator malformed")

  // Ordinary characters carry no length, are never NUL, and more follow.
  `ITOA_ASSERT_IMP(a_char_body, out_strobe && !out_last,
    (out_total_length == '0) && (out_character != ASCII_NUL) && busy,
    "character before terminator malformed")

  // The controller never divides and emits or loads in the same cycle.
  `ITOA_ASSERT_IMP(a_cmd_excl, cmd.div_step,
    !(cmd.emit_sign || cmd.emit_digit || cmd.emit_term || cmd.load),
    "divide step overlaps another command")

endmodule
